// ===== rtl/lds_pkg.sv =====
// shared constants, types and helpers for the linear diophantine solver
// no dependencies; used by rtl/linear_diophantine_solver.sv

package lds_pkg;

    // coefficient width and the widths that follow from it
    localparam int COEF_W   = 16;
    localparam int REM_W    = COEF_W + 1;          // remainders, quotients, gcd
    localparam int BZ_W     = COEF_W + 2;          // bezout coefficients
    localparam int PROD_W   = 2 * BZ_W;
    localparam int WORD_W   = 32;                  // sol_x, sol_y
    localparam int GCD_W    = 17;                  // divisor field
    localparam int EXT_W    = (PROD_W > WORD_W) ? PROD_W : WORD_W;
    localparam int CNT_W    = $clog2(REM_W + 1);

    // stream packing
    localparam int IN_W       = 3 * COEF_W;
    localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W      = 2 * WORD_W + GCD_W;
    localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // solution walk k = SIDE_COUNT .. -SIDE_COUNT
    localparam int SIDE_COUNT = 5;
    localparam int LAST_IDX   = 2 * SIDE_COUNT;
    localparam int IDX_W      = $clog2(LAST_IDX + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EUC,
        ST_DIV,
        ST_UPD_S,
        ST_UPD_T,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_OUT,
        ST_NOSOL
    } state_t;

    typedef enum logic [1:0] {
        OP_EUC,
        OP_C,
        OP_A,
        OP_B
    } div_op_t;

    function automatic logic [WORD_W-1:0] to_word(input logic signed [REM_W-1:0] v);
        logic signed [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[WORD_W-1:0];
    endfunction

    function automatic logic [GCD_W-1:0] to_gcd(input logic signed [REM_W-1:0] v);
        logic signed [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[GCD_W-1:0];
    endfunction

endpackage

// ===== rtl/linear_diophantine_solver.sv =====
// linear diophantine solver a*x + b*y = c, top level
// depends on rtl/lds_pkg.sv
//
// sequence: each euclid step is a load state, the bit-serial divider, a result state and the
// multiplier states ST_UPD_S and ST_UPD_T; the finish is a load state, three divisions
// (c/g, a/g, b/g), the multiplier states ST_MUL_X to ST_MUL_DY and the walk of the solutions
// throughput: one word at a time, s_tready high only in idle
// reset: synchronous active-low aresetn clears the sequencer and the output valid

module linear_diophantine_solver (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave side: coef_a, coef_b, rhs_c from bit 0 up
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lds_pkg::S_TDATA_W-1:0]  s_tdata,
    // master side: sol_x, sol_y, divisor from bit 0 up, zero padded
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lds_pkg::M_TDATA_W-1:0]  m_tdata,
    // solvable flag
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast
);

    localparam int REM_W  = lds_pkg::REM_W;
    localparam int BZ_W   = lds_pkg::BZ_W;
    localparam int COEF_W = lds_pkg::COEF_W;

    // sequencer
    lds_pkg::state_t  state_reg, state_next;
    lds_pkg::div_op_t div_op_reg, div_op_next;

    // input word
    logic signed [REM_W-1:0] a_reg, a_next;
    logic signed [REM_W-1:0] b_reg, b_next;
    logic signed [REM_W-1:0] c_reg, c_next;
    logic                    one_zero_reg, one_zero_next;

    // euclid state: old remainder ends up as g
    logic signed [REM_W-1:0] or_reg, or_next;
    logic signed [REM_W-1:0] r_reg, r_next;
    logic signed [REM_W-1:0] q_reg, q_next;
    logic signed [BZ_W-1:0]  os_reg, os_next;
    logic signed [BZ_W-1:0]  s_reg, s_next;
    logic signed [BZ_W-1:0]  ot_reg, ot_next;
    logic signed [BZ_W-1:0]  t_reg, t_next;

    // finish values
    logic signed [REM_W-1:0] cq_reg, cq_next;
    logic signed [REM_W-1:0] da_reg, da_next;
    logic signed [REM_W-1:0] db_reg, db_next;
    logic [lds_pkg::WORD_W-1:0] cur_x_reg, cur_x_next;
    logic [lds_pkg::WORD_W-1:0] cur_y_reg, cur_y_next;
    logic [lds_pkg::IDX_W-1:0]  idx_reg, idx_next;

    // shared restoring divider, magnitudes only
    logic [REM_W-1:0]          dv_rem_reg, dv_rem_next;
    logic [REM_W-1:0]          dv_quo_reg, dv_quo_next;
    logic [REM_W-1:0]          dv_den_reg, dv_den_next;
    logic                      dv_qneg_reg, dv_qneg_next;
    logic                      dv_rneg_reg, dv_rneg_next;
    logic [lds_pkg::CNT_W-1:0] dv_cnt_reg, dv_cnt_next;

    // output register
    logic                             m_tvalid_reg, m_tvalid_next;
    logic                             solv_reg, solv_next;
    logic [lds_pkg::WORD_W-1:0]       ox_reg, ox_next;
    logic [lds_pkg::WORD_W-1:0]       oy_reg, oy_next;
    logic [lds_pkg::GCD_W-1:0]        og_reg, og_next;
    logic                             olast_reg, olast_next;

    // input fields
    logic signed [COEF_W-1:0] in_a, in_b, in_c;
    assign in_a = s_tdata[COEF_W-1:0];
    assign in_b = s_tdata[2*COEF_W-1:COEF_W];
    assign in_c = s_tdata[3*COEF_W-1:2*COEF_W];

    logic in_fire;
    assign in_fire = s_tvalid && s_tready;

    // divider step and signed results
    logic [REM_W-1:0]        dv_shift;
    logic                    dv_ge;
    logic                    dv_busy;
    logic signed [REM_W-1:0] dv_quo_s, dv_rem_s;
    assign dv_shift = {dv_rem_reg[REM_W-2:0], dv_quo_reg[REM_W-1]};
    assign dv_ge    = dv_shift >= dv_den_reg;
    assign dv_busy  = dv_cnt_reg != '0;
    assign dv_quo_s = dv_qneg_reg ? -$signed(dv_quo_reg) : $signed(dv_quo_reg);
    assign dv_rem_s = dv_rneg_reg ? -$signed(dv_rem_reg) : $signed(dv_rem_reg);

    // output slot and solution walk
    logic out_free;
    logic out_skip;
    logic out_last;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_skip = (idx_reg == lds_pkg::IDX_W'(lds_pkg::SIDE_COUNT)) && !one_zero_reg;
    assign out_last = idx_reg == lds_pkg::IDX_W'(lds_pkg::LAST_IDX);

    // shared multiplier
    logic signed [BZ_W-1:0]            mul_l, mul_r;
    logic signed [lds_pkg::PROD_W-1:0] prod;
    logic signed [lds_pkg::EXT_W-1:0]  prod_ext;
    logic [lds_pkg::WORD_W-1:0]        prod_word;
    assign prod      = mul_l * mul_r;
    assign prod_ext  = lds_pkg::EXT_W'(prod);
    assign prod_word = prod_ext[lds_pkg::WORD_W-1:0];

    always_comb begin
        unique case (state_reg)
            lds_pkg::ST_UPD_S: begin
                mul_l = BZ_W'(q_reg);
                mul_r = s_reg;
            end
            lds_pkg::ST_UPD_T: begin
                mul_l = BZ_W'(q_reg);
                mul_r = t_reg;
            end
            lds_pkg::ST_MUL_X: begin
                mul_l = BZ_W'(cq_reg);
                mul_r = os_reg;
            end
            lds_pkg::ST_MUL_Y: begin
                mul_l = BZ_W'(cq_reg);
                mul_r = ot_reg;
            end
            lds_pkg::ST_MUL_DX: begin
                mul_l = BZ_W'(lds_pkg::SIDE_COUNT);
                mul_r = BZ_W'(db_reg);
            end
            lds_pkg::ST_MUL_DY: begin
                mul_l = BZ_W'(lds_pkg::SIDE_COUNT);
                mul_r = BZ_W'(da_reg);
            end
            default: begin
                mul_l = '0;
                mul_r = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lds_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_a == '0 && in_b == '0) state_next = lds_pkg::ST_NOSOL;
                    else                          state_next = lds_pkg::ST_EUC;
                end
            end
            lds_pkg::ST_EUC:   state_next = lds_pkg::ST_DIV;
            lds_pkg::ST_DIV: begin
                if (!dv_busy) begin
                    unique case (div_op_reg)
                        lds_pkg::OP_EUC: state_next = lds_pkg::ST_UPD_S;
                        lds_pkg::OP_C: begin
                            if (dv_rem_reg != '0) state_next = lds_pkg::ST_NOSOL;
                        end
                        lds_pkg::OP_A: state_next = lds_pkg::ST_DIV;
                        lds_pkg::OP_B: state_next = lds_pkg::ST_MUL_X;
                        default:       state_next = lds_pkg::ST_IDLE;
                    endcase
                end
            end
            lds_pkg::ST_UPD_S:  state_next = lds_pkg::ST_UPD_T;
            lds_pkg::ST_UPD_T:  state_next = lds_pkg::ST_EUC;
            lds_pkg::ST_MUL_X:  state_next = lds_pkg::ST_MUL_Y;
            lds_pkg::ST_MUL_Y:  state_next = lds_pkg::ST_MUL_DX;
            lds_pkg::ST_MUL_DX: state_next = lds_pkg::ST_MUL_DY;
            lds_pkg::ST_MUL_DY: state_next = lds_pkg::ST_OUT;
            lds_pkg::ST_OUT: begin
                if (!out_skip && out_free && out_last) state_next = lds_pkg::ST_IDLE;
            end
            lds_pkg::ST_NOSOL: begin
                if (out_free) state_next = lds_pkg::ST_IDLE;
            end
            default: state_next = lds_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register
    logic                    dv_start;
    logic signed [REM_W-1:0] dv_num, dv_den;
    logic                    out_load;

    always_comb begin
        div_op_next   = div_op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        one_zero_next = one_zero_reg;
        or_next       = or_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        os_next       = os_reg;
        s_next        = s_reg;
        ot_next       = ot_reg;
        t_next        = t_reg;
        cq_next       = cq_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        idx_next      = idx_reg;
        dv_rem_next   = dv_rem_reg;
        dv_quo_next   = dv_quo_reg;
        dv_den_next   = dv_den_reg;
        dv_qneg_next  = dv_qneg_reg;
        dv_rneg_next  = dv_rneg_reg;
        dv_cnt_next   = dv_cnt_reg;
        solv_next     = solv_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        og_next       = og_reg;
        olast_next    = olast_reg;
        dv_start      = 1'b0;
        dv_num        = or_reg;
        dv_den        = r_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            lds_pkg::ST_IDLE: begin
                if (in_fire) begin
                    a_next        = REM_W'(in_a);
                    b_next        = REM_W'(in_b);
                    c_next        = REM_W'(in_c);
                    one_zero_next = (in_a == '0) != (in_b == '0);
                    // both zero: or stays a, which is zero, as the reported divisor
                    or_next       = REM_W'(in_a);
                    r_next        = REM_W'(in_b);
                    os_next       = BZ_W'(1);
                    s_next        = '0;
                    ot_next       = '0;
                    t_next        = BZ_W'(1);
                end
            end
            lds_pkg::ST_EUC: begin
                dv_start = 1'b1;
                if (r_reg == '0) begin
                    // gcd found, test whether it divides c
                    dv_num      = c_reg;
                    dv_den      = or_reg;
                    div_op_next = lds_pkg::OP_C;
                end else begin
                    dv_num      = or_reg;
                    dv_den      = r_reg;
                    div_op_next = lds_pkg::OP_EUC;
                end
            end
            lds_pkg::ST_DIV: begin
                if (dv_busy) begin
                    dv_rem_next = dv_ge ? dv_shift - dv_den_reg : dv_shift;
                    dv_quo_next = {dv_quo_reg[REM_W-2:0], dv_ge};
                    dv_cnt_next = dv_cnt_reg - 1'b1;
                end else begin
                    unique case (div_op_reg)
                        lds_pkg::OP_EUC: begin
                            or_next = r_reg;
                            r_next  = dv_rem_s;
                            q_next  = dv_quo_s;
                        end
                        lds_pkg::OP_C: begin
                            cq_next = dv_quo_s;
                            if (dv_rem_reg == '0) begin
                                dv_start    = 1'b1;
                                dv_num      = a_reg;
                                dv_den      = or_reg;
                                div_op_next = lds_pkg::OP_A;
                            end
                        end
                        lds_pkg::OP_A: begin
                            da_next     = dv_quo_s;
                            dv_start    = 1'b1;
                            dv_num      = b_reg;
                            dv_den      = or_reg;
                            div_op_next = lds_pkg::OP_B;
                        end
                        lds_pkg::OP_B: begin
                            db_next = dv_quo_s;
                        end
                        default: ;
                    endcase
                end
            end
            lds_pkg::ST_UPD_S: begin
                s_next  = os_reg - prod[BZ_W-1:0];
                os_next = s_reg;
            end
            lds_pkg::ST_UPD_T: begin
                t_next  = ot_reg - prod[BZ_W-1:0];
                ot_next = t_reg;
            end
            lds_pkg::ST_MUL_X:  cur_x_next = prod_word;
            lds_pkg::ST_MUL_Y:  cur_y_next = prod_word;
            lds_pkg::ST_MUL_DX: cur_x_next = cur_x_reg + prod_word;
            lds_pkg::ST_MUL_DY: begin
                cur_y_next = cur_y_reg - prod_word;
                idx_next   = '0;
            end
            lds_pkg::ST_OUT: begin
                if (out_skip || out_free) begin
                    // walk k down by one: x moves by -b/g, y by +a/g
                    cur_x_next = cur_x_reg - lds_pkg::to_word(db_reg);
                    cur_y_next = cur_y_reg + lds_pkg::to_word(da_reg);
                    idx_next   = idx_reg + 1'b1;
                    if (!out_skip) begin
                        out_load   = 1'b1;
                        solv_next  = 1'b1;
                        ox_next    = cur_x_reg;
                        oy_next    = cur_y_reg;
                        og_next    = lds_pkg::to_gcd(or_reg);
                        olast_next = out_last;
                    end
                end
            end
            lds_pkg::ST_NOSOL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    solv_next  = 1'b0;
                    ox_next    = '0;
                    oy_next    = '0;
                    og_next    = lds_pkg::to_gcd(or_reg);
                    olast_next = 1'b1;
                end
            end
            default: ;
        endcase

        // divider load, magnitudes and result signs as in c
        if (dv_start) begin
            dv_rneg_next = dv_num[REM_W-1];
            dv_qneg_next = dv_num[REM_W-1] ^ dv_den[REM_W-1];
            dv_quo_next  = dv_num[REM_W-1] ? REM_W'(-dv_num) : REM_W'(dv_num);
            dv_den_next  = dv_den[REM_W-1] ? REM_W'(-dv_den) : REM_W'(dv_den);
            dv_rem_next  = '0;
            dv_cnt_next  = lds_pkg::CNT_W'(REM_W);
        end

        if (out_load)      m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else               m_tvalid_next = m_tvalid_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lds_pkg::ST_IDLE;
            dv_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dv_cnt_reg   <= dv_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        div_op_reg   <= div_op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        one_zero_reg <= one_zero_next;
        or_reg       <= or_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        os_reg       <= os_next;
        s_reg        <= s_next;
        ot_reg       <= ot_next;
        t_reg        <= t_next;
        cq_reg       <= cq_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        idx_reg      <= idx_next;
        dv_rem_reg   <= dv_rem_next;
        dv_quo_reg   <= dv_quo_next;
        dv_den_reg   <= dv_den_next;
        dv_qneg_reg  <= dv_qneg_next;
        dv_rneg_reg  <= dv_rneg_next;
        solv_reg     <= solv_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        og_reg       <= og_next;
        olast_reg    <= olast_next;
    end

    // ports
    assign s_tready   = state_reg == lds_pkg::ST_IDLE;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = lds_pkg::M_TDATA_W'({og_reg, oy_reg, ox_reg});
    assign m_tuser[0] = solv_reg;
    assign m_tlast    = olast_reg;

endmodule

// ===== bench/lds_checker.sv =====
// predictor and scoreboard for the linear diophantine solver
// depends on rtl/lds_pkg.sv; instantiated by bench/linear_diophantine_solver_tb.sv

module lds_checker
    import lds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    solutions_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                     solvable;
        logic signed [WORD_W-1:0] sol_x;
        logic signed [WORD_W-1:0] sol_y;
        logic signed [GCD_W-1:0]  divisor;
        logic                     last;
    } solution_t;

    solution_t solution_q[$];

    function automatic void queue_solution(input bit ok, input longint x, input longint y,
                                           input longint g, input bit fin);
        solution_t sol;
        sol.solvable = ok;
        sol.sol_x    = x[WORD_W-1:0];
        sol.sol_y    = y[WORD_W-1:0];
        sol.divisor  = g[GCD_W-1:0];
        sol.last     = fin;
        solution_q   = {solution_q, sol};
    endfunction

    // extended euclid with truncating division, then the walk along the solution line
    function automatic void predict_solutions(input logic [S_TDATA_W-1:0] word);
        logic signed [COEF_W-1:0] fa, fb, fc;
        longint a, b, c, r_old, r, s_old, s, t_old, t, q, tmp, x0, y0, da, db;
        int guard;
        fa = word[COEF_W-1:0];
        fb = word[2*COEF_W-1:COEF_W];
        fc = word[3*COEF_W-1:2*COEF_W];
        a = fa;
        b = fb;
        c = fc;
        if (a == 0 && b == 0) begin
            queue_solution(1'b0, 0, 0, 0, 1'b1);
            return;
        end
        r_old = a; r = b; s_old = 1; s = 0; t_old = 0; t = 1;
        guard = 0;
        while (r != 0 && guard < 200) begin
            q = r_old / r;
            tmp = r_old - q * r; r_old = r; r = tmp;
            tmp = s_old - q * s; s_old = s; s = tmp;
            tmp = t_old - q * t; t_old = t; t = tmp;
            guard++;
        end
        // gcd can be negative here, so it does not divide c by sign alone
        if (r_old == 0 || (c % r_old) != 0) begin
            queue_solution(1'b0, 0, 0, r_old, 1'b1);
            return;
        end
        x0 = (c * s_old) / r_old;
        y0 = (c * t_old) / r_old;
        db = b / r_old;
        da = a / r_old;
        for (int k = SIDE_COUNT; k >= 1; k--)
            queue_solution(1'b1, x0 + k * db, y0 - k * da, r_old, 1'b0);
        // the particular solution itself only shows up with exactly one zero coefficient
        if ((a == 0) != (b == 0))
            queue_solution(1'b1, x0, y0, r_old, 1'b0);
        for (int k = 1; k <= SIDE_COUNT; k++)
            queue_solution(1'b1, x0 - k * db, y0 + k * da, r_old, k == SIDE_COUNT);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count = 0;
            solutions_owed = 0;
            solution_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_solutions(s_tdata);
            if (m_tvalid && m_tready) begin
                if (solution_q.size() == 0) begin
                    $error("unexpected result word: x=%0d y=%0d g=%0d",
                           $signed(m_tdata[WORD_W-1:0]),
                           $signed(m_tdata[2*WORD_W-1:WORD_W]),
                           $signed(m_tdata[OUT_W-1:2*WORD_W]));
                    fail_count++;
                end else begin
                    check_field("solvable", solution_q[0].solvable, m_tuser[0]);
                    check_field("sol_x", solution_q[0].sol_x,
                                $signed(m_tdata[WORD_W-1:0]));
                    check_field("sol_y", solution_q[0].sol_y,
                                $signed(m_tdata[2*WORD_W-1:WORD_W]));
                    check_field("divisor", solution_q[0].divisor,
                                $signed(m_tdata[OUT_W-1:2*WORD_W]));
                    check_field("tdata padding", 0,
                                longint'(m_tdata[M_TDATA_W-1:OUT_W]));
                    check_field("last", solution_q[0].last, m_tlast);
                    void'(solution_q.pop_front());
                end
            end
            solutions_owed = solution_q.size();
        end
    end

endmodule

// ===== bench/linear_diophantine_solver_tb.sv =====
// stimulus and verdict for the linear diophantine solver
// depends on rtl/lds_pkg.sv, rtl/linear_diophantine_solver.sv and bench/lds_checker.sv

module linear_diophantine_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lds_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int IDLE_LIMIT   = 5000;  // well above the longest euclid run plus a stall
    localparam int DRAIN_CYCLES = 600;   // margin for any stray word after the drain
    localparam int RANDOM_WORDS = 76;
    localparam logic [12:0] READY_MASK = 13'b1011001110101;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // coef_a, coef_b, rhs_c from bit 0 up
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // sol_x, sol_y, divisor from bit 0 up, zero padded
    logic [M_TDATA_W-1:0]  m_tdata;
    // solvable
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    int fail_count;
    int solutions_owed;
    int burst_left  = 0;
    int ready_cyc   = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int fib[0:23];
    int edge_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    always #1 aclk = ~aclk;

    linear_diophantine_solver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lds_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .solutions_owed (solutions_owed)
    );

    // present one coefficient word; the sender runs in bursts with random gaps between
    task automatic send_coefs(input int a, input int b, input int c);
        int gap;
        if (burst_left == 0) begin
            // a burst of zero gap keeps valid high straight into the next burst
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= S_TDATA_W'({$urandom, $urandom});
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // receiver: phases of always ready, a fixed mask, random stalls and long stalls
    always @(negedge aclk) begin
        case ((ready_cyc / 300) % 4)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= READY_MASK[ready_cyc % 13];
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 24);
                end
            end
        endcase
        ready_cyc++;
    end

    // watchdog: too long without a word moving on either side ends the run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int a, b, c, g, n;
        fib[0] = 0;
        fib[1] = 1;
        for (int i = 2; i < 24; i++)
            fib[i] = fib[i-1] + fib[i-2];

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // both coefficients zero, with and without a constant
        send_coefs(0, 0, 0);
        send_coefs(0, 0, 5);
        send_coefs(0, 0, -32768);
        // exactly one coefficient zero, the particular solution is emitted too
        send_coefs(0, 7, 21);
        send_coefs(6, 0, -18);
        send_coefs(0, -32768, -32768);
        send_coefs(0, 1, -32768);
        send_coefs(-1, 0, 32767);
        // gcd does not divide the constant
        send_coefs(4, 6, 5);
        send_coefs(-32768, 0, 32767);
        send_coefs(32767, 32767, -32768);
        // sign combinations, negative gcd included
        send_coefs(3, 5, 7);
        send_coefs(-3, 5, 7);
        send_coefs(3, -5, -7);
        send_coefs(-12, -18, 30);
        send_coefs(12, 18, -30);
        // extremes, large bezout coefficients
        send_coefs(32767, -32768, 32767);
        send_coefs(-32768, 32767, -32768);
        send_coefs(-32768, -32768, -32768);
        send_coefs(-32768, -32767, 1);
        send_coefs(32767, 32766, -1);
        // zero constant and longest euclid chain
        send_coefs(1, 1, 0);
        send_coefs(-1, -1, 32767);
        send_coefs(28657, 17711, 32767);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // common factor times random multipliers
                    g = int'($urandom_range(1, 64));
                    a = g * (int'($urandom_range(0, 1022)) - 511);
                    b = g * (int'($urandom_range(0, 1022)) - 511);
                    c = g * (int'($urandom_range(0, 1022)) - 511);
                end
                5, 6: begin
                    a = $urandom;
                    b = $urandom;
                    c = $urandom;
                end
                7: begin
                    // one coefficient zero
                    g = $urandom;
                    a = ($urandom_range(0, 1) != 0) ? g : 0;
                    b = (a == 0) ? g : 0;
                    c = ($urandom_range(0, 1) != 0) ? $urandom
                                                     : g * int'($urandom_range(0, 3));
                end
                8: begin
                    a = edge_vals[$urandom_range(0, 6)];
                    b = edge_vals[$urandom_range(0, 6)];
                    c = ($urandom_range(0, 1) != 0) ? edge_vals[$urandom_range(0, 6)]
                                                     : $urandom;
                end
                default: begin
                    // neighboring fibonacci numbers drive euclid to many steps
                    n = $urandom_range(10, 22);
                    a = ($urandom_range(0, 1) != 0) ? fib[n+1] : -fib[n+1];
                    b = ($urandom_range(0, 1) != 0) ? fib[n] : -fib[n];
                    c = $urandom;
                end
            endcase
            send_coefs(a, b, c);
        end
        s_tvalid <= 1'b0;

        // drain, then give the block time to show any stray word
        while (solutions_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lds_pkg.sv
rtl/linear_diophantine_solver.sv
bench/lds_checker.sv
bench/linear_diophantine_solver_tb.sv
